[rtl/sed_pkg.sv]
// shared types, codes and helpers for the string escape decoder
// no dependencies
package sed_pkg;

  typedef enum logic [2:0] {
    MODE_BODY   = 3'd0,
    MODE_ESC    = 3'd1,
    MODE_HEX    = 3'd2,
    MODE_UBRACE = 3'd3,
    MODE_UDIG   = 3'd4,
    MODE_SKIP   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_UNTERM   = 3'd1,
    STAT_BAD_HEX  = 3'd2,
    STAT_NO_BRACE = 3'd3,
    STAT_NONHEX   = 3'd4,
    STAT_RANGE    = 3'd5,
    STAT_EMPTY    = 3'd6,
    STAT_UNKNOWN  = 3'd7
  } status_t;

  localparam logic [7:0] ChQuote  = 8'h22;
  localparam logic [7:0] ChNl     = 8'h0a;
  localparam logic [7:0] ChCr     = 8'h0d;
  localparam logic [7:0] ChTab    = 8'h09;
  localparam logic [7:0] ChNul    = 8'h00;
  localparam logic [7:0] ChBslash = 8'h5c;
  localparam logic [7:0] ChZero   = 8'h30;
  localparam logic [7:0] ChLowN   = 8'h6e;
  localparam logic [7:0] ChLowR   = 8'h72;
  localparam logic [7:0] ChLowT   = 8'h74;
  localparam logic [7:0] ChLowX   = 8'h78;
  localparam logic [7:0] ChLowU   = 8'h75;
  localparam logic [7:0] ChLbrace = 8'h7b;
  localparam logic [7:0] ChRbrace = 8'h7d;

  localparam logic [24:0] CpMax    = 25'h10ffff;
  localparam logic [20:0] Utf8Lim1 = 21'h80;
  localparam logic [20:0] Utf8Lim2 = 21'h800;
  localparam logic [20:0] Utf8Lim3 = 21'h10000;

  // decoder state carried from one word to the next
  typedef struct packed {
    mode_t       mode;
    logic [7:0]  hex_acc;
    logic [1:0]  hex_count;
    logic [20:0] code_point;
    logic        digit_seen;
    logic [2:0]  error_code;
  } sed_state_t;

  // all result words caused by one input word
  typedef struct packed {
    logic [2:0]       cnt;       // 0 to 4 words
    logic             end_item;
    logic [2:0]       status;
    logic             term;
    logic [3:0][7:0]  bytes;     // bytes[0] goes out first
  } sed_result_t;

  localparam sed_state_t StateReset = '{
    mode: MODE_BODY, hex_acc: 8'd0, hex_count: 2'd0,
    code_point: 21'd0, digit_seen: 1'b0, error_code: 3'd0
  };

  // {valid, value} of an ascii hex digit
  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) r = {1'b1, c[3:0]};
    else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46))
      r = {1'b1, c[3:0] + 4'd9};
    return r;
  endfunction

endpackage

[rtl/sed_step.sv]
// next state and result words for one input byte of the escape decoder
// depends on sed_pkg
module sed_step (
  input  sed_pkg::sed_state_t  st,
  input  logic [7:0]           src_byte,
  input  logic                 at_end,
  output sed_pkg::sed_state_t  st_next,
  output sed_pkg::sed_result_t res
);

  logic [7:0]  c;
  logic [4:0]  hv;
  logic [24:0] cp_wide;
  logic [20:0] cp;

  assign c       = at_end ? sed_pkg::ChNul : src_byte;
  assign hv      = sed_pkg::hex_val(c);
  assign cp_wide = {st.code_point, hv[3:0]};
  assign cp      = st.code_point;

  always_comb begin
    st_next = st;
    res     = '0;

    unique case (st.mode)
      sed_pkg::MODE_ESC: begin
        st_next.mode = sed_pkg::MODE_BODY;
        res.cnt      = 3'd1;
        unique case (c)
          sed_pkg::ChLowN:   res.bytes[0] = sed_pkg::ChNl;
          sed_pkg::ChLowR:   res.bytes[0] = sed_pkg::ChCr;
          sed_pkg::ChLowT:   res.bytes[0] = sed_pkg::ChTab;
          sed_pkg::ChZero:   res.bytes[0] = sed_pkg::ChNul;
          sed_pkg::ChBslash: res.bytes[0] = sed_pkg::ChBslash;
          sed_pkg::ChQuote:  res.bytes[0] = sed_pkg::ChQuote;
          sed_pkg::ChLowX: begin
            res.cnt           = 3'd0;
            st_next.mode      = sed_pkg::MODE_HEX;
            st_next.hex_acc   = 8'd0;
            st_next.hex_count = 2'd0;
          end
          sed_pkg::ChLowU: begin
            res.cnt      = 3'd0;
            st_next.mode = sed_pkg::MODE_UBRACE;
          end
          sed_pkg::ChNul: begin
            res.end_item = 1'b1;
            res.status   = sed_pkg::STAT_UNKNOWN;
            st_next      = sed_pkg::StateReset;
          end
          default: begin
            res.cnt            = 3'd0;
            st_next.error_code = sed_pkg::STAT_UNKNOWN;
            st_next.mode       = sed_pkg::MODE_SKIP;
          end
        endcase
      end

      sed_pkg::MODE_HEX: begin
        if (hv[4]) begin
          if (st.hex_count != 2'd0) begin
            res.cnt      = 3'd1;
            res.bytes[0] = {st.hex_acc[3:0], hv[3:0]};
            st_next      = sed_pkg::StateReset;
            st_next.error_code = st.error_code;
          end else begin
            st_next.hex_acc   = {st.hex_acc[3:0], hv[3:0]};
            st_next.hex_count = st.hex_count + 2'd1;
          end
        end else begin
          st_next.error_code = sed_pkg::STAT_BAD_HEX;
        end
      end

      sed_pkg::MODE_UBRACE: begin
        if (c == sed_pkg::ChLbrace) begin
          st_next.mode       = sed_pkg::MODE_UDIG;
          st_next.code_point = 21'd0;
          st_next.digit_seen = 1'b0;
        end else begin
          st_next.error_code = sed_pkg::STAT_NO_BRACE;
        end
      end

      sed_pkg::MODE_UDIG: begin
        if (c == sed_pkg::ChRbrace) begin
          if (!st.digit_seen) begin
            st_next.error_code = sed_pkg::STAT_EMPTY;
            st_next.mode       = sed_pkg::MODE_SKIP;
          end else begin
            st_next.mode       = sed_pkg::MODE_BODY;
            st_next.code_point = 21'd0;
            st_next.digit_seen = 1'b0;
            // utf-8 encoding of the finished code point
            if (cp < sed_pkg::Utf8Lim1) begin
              res.cnt      = 3'd1;
              res.bytes[0] = cp[7:0];
            end else if (cp < sed_pkg::Utf8Lim2) begin
              res.cnt      = 3'd2;
              res.bytes[0] = {3'b110, cp[10:6]};
              res.bytes[1] = {2'b10, cp[5:0]};
            end else if (cp < sed_pkg::Utf8Lim3) begin
              res.cnt      = 3'd3;
              res.bytes[0] = {4'b1110, cp[15:12]};
              res.bytes[1] = {2'b10, cp[11:6]};
              res.bytes[2] = {2'b10, cp[5:0]};
            end else begin
              res.cnt      = 3'd4;
              res.bytes[0] = {5'b11110, cp[20:18]};
              res.bytes[1] = {2'b10, cp[17:12]};
              res.bytes[2] = {2'b10, cp[11:6]};
              res.bytes[3] = {2'b10, cp[5:0]};
            end
          end
        end else if (hv[4]) begin
          st_next.digit_seen = 1'b1;
          if (cp_wide > sed_pkg::CpMax) begin
            st_next.error_code = sed_pkg::STAT_RANGE;
            st_next.mode       = sed_pkg::MODE_SKIP;
          end else begin
            st_next.code_point = cp_wide[20:0];
          end
        end else begin
          st_next.error_code = sed_pkg::STAT_NONHEX;
        end
      end

      sed_pkg::MODE_SKIP: ;

      default: begin
        if (c == sed_pkg::ChQuote) begin
          res.cnt      = 3'd1;
          res.end_item = 1'b1;
          res.status   = sed_pkg::STAT_OK;
          res.term     = 1'b1;
          st_next      = sed_pkg::StateReset;
        end else if (c == sed_pkg::ChNl || c == sed_pkg::ChNul) begin
          res.cnt      = 3'd1;
          res.end_item = 1'b1;
          res.status   = sed_pkg::STAT_UNTERM;
          st_next      = sed_pkg::StateReset;
        end else if (c == sed_pkg::ChBslash) begin
          st_next.mode = sed_pkg::MODE_ESC;
        end else begin
          res.cnt      = 3'd1;
          res.bytes[0] = c;
        end
      end
    endcase

    // skip handling: in skip mode, and on the byte that failed \x, a missing
    // brace or a non-hex \u digit, which is examined as the first skipped byte
    if (st.mode == sed_pkg::MODE_SKIP ||
        (st.mode == sed_pkg::MODE_HEX && !hv[4]) ||
        (st.mode == sed_pkg::MODE_UBRACE && c != sed_pkg::ChLbrace) ||
        (st.mode == sed_pkg::MODE_UDIG && c != sed_pkg::ChRbrace && !hv[4])) begin
      if (c == sed_pkg::ChQuote || c == sed_pkg::ChNl || c == sed_pkg::ChNul) begin
        res          = '0;
        res.cnt      = 3'd1;
        res.end_item = 1'b1;
        res.status   = st_next.error_code;
        res.term     = (c == sed_pkg::ChQuote);
        st_next      = sed_pkg::StateReset;
      end else begin
        st_next.mode = sed_pkg::MODE_SKIP;
      end
    end
  end

endmodule

[rtl/string_escape_decoder.sv]
// string literal escape decoder, top level with input handshake and result buffer
// depends on sed_pkg and sed_step
//
// Takes the body bytes of a single-line string literal, one word per cycle, and
// returns the decoded bytes followed by one end word per literal carrying a
// status and whether the closing quote was consumed. Escapes \n \r \t \0 \\ \"
// and \xHH give one byte; \u{hex} gives one to four UTF-8 bytes. The first
// escape error is kept and the rest of the literal is skipped up to a quote,
// newline, NUL or end of source. Each input word is decoded in the cycle it is
// accepted and all of its result words land in a four-byte result buffer, which
// drains one word per cycle while out_ready is high. A new input word is taken
// whenever the buffer is empty or its final word leaves in the same cycle, so
// plain text runs at one word per cycle when out_ready stays high; a \u escape
// that encodes to more than one byte holds off input while the buffer drains.
// `last` marks the final result word of each input word.
module string_escape_decoder (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] src_byte,
  input  logic       at_end,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       item_kind,
  output logic [7:0] data_byte,
  output logic [2:0] status,
  output logic       terminator_used,
  output logic       last
);

  sed_pkg::sed_state_t  st;
  sed_pkg::sed_state_t  st_next;
  sed_pkg::sed_result_t res;
  sed_pkg::sed_result_t out_buf;   // result words waiting to go out
  logic [1:0]           idx;       // next word of out_buf to show
  logic                 full;
  logic                 in_acc;
  logic                 out_acc;

  sed_step u_step (
    .st       (st),
    .src_byte (src_byte),
    .at_end   (at_end),
    .st_next  (st_next),
    .res      (res)
  );

  assign last      = ({1'b0, idx} == out_buf.cnt - 3'd1);
  assign out_valid = full;
  assign out_acc   = out_valid && out_ready;
  // take a new word when the buffer is empty or is handing out its final word
  assign in_ready  = !full || (out_ready && last);
  assign in_acc    = in_valid && in_ready;

  assign item_kind       = out_buf.end_item;
  assign data_byte       = out_buf.end_item ? 8'd0 : out_buf.bytes[idx];
  assign status          = out_buf.status;
  assign terminator_used = out_buf.term;

  // decoder state
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= sed_pkg::StateReset;
    end else if (in_acc) begin
      st <= st_next;
    end
  end

  // result buffer control
  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
      idx  <= 2'd0;
    end else if (in_acc) begin
      full <= (res.cnt != 3'd0);
      idx  <= 2'd0;
    end else if (out_acc) begin
      if (last) begin
        full <= 1'b0;
      end else begin
        idx <= idx + 2'd1;
      end
    end
  end

  // result buffer payload
  always_ff @(posedge clk) begin
    if (in_acc && res.cnt != 3'd0) begin
      out_buf <= res;
    end
  end

endmodule
